>>> hdl/bpg_pkg.sv
// Package for the biphasic pulse generator: widths, reset values, default bounds,
// register and phase codes. No dependencies.
package bpg_pkg;

  // Field widths
  localparam int FREQ_W  = 10;
  localparam int WIDTH_W = 16;
  localparam int AMP_W   = 11;
  localparam int GAP_W   = 10;
  localparam int DUTY_W  = 10;
  localparam int POS_W   = 20;
  localparam int PHASE_W = 2;

  // Default safe bounds
  localparam int unsigned FREQ_MIN_HZ_DEF  = 1;
  localparam int unsigned FREQ_MAX_HZ_DEF  = 200;
  localparam int unsigned WIDTH_MIN_US_DEF = 50;
  localparam int unsigned WIDTH_MAX_US_DEF = 500;
  localparam int unsigned AMP_MIN_Q10_DEF  = 0;
  localparam int unsigned AMP_MAX_Q10_DEF  = 1024;

  // Register reset values
  localparam logic [FREQ_W-1:0]  FREQ_RST  = 10'd100;
  localparam logic [WIDTH_W-1:0] WIDTH_RST = 16'd100;
  localparam logic [AMP_W-1:0]   AMP_RST   = 11'd512;
  localparam logic [GAP_W-1:0]   GAP_RST   = 10'd50;

  // Microseconds per second, dividend of the period division
  localparam logic [POS_W-1:0] US_PER_S  = 20'd1000000;
  localparam int               DIV_STEPS = POS_W;

  // Register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_FREQ  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_AMP   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BIPH  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_EN    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GAP   = 3'd5;
  localparam int PADDR_W = REG_IDX_W + 2;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_POS  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_GAP  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_NEG  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_REST = 2'd3;

  typedef logic [PHASE_W-1:0] phase_t;

endpackage

>>> hdl/bpg_if.sv
// Valid/ready channel interfaces for the tick input and the drive result.
// Depends on bpg_pkg.
interface bpg_in_if import bpg_pkg::*; ();
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink   (input valid, input advance, output ready);
endinterface

interface bpg_out_if import bpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] drive_duty;
  logic              polarity_positive;
  phase_t            phase;
  logic              period_start;

  modport source (output valid, output drive_duty, output polarity_positive,
                  output phase, output period_start, input ready);
  modport sink   (input valid, input drive_duty, input polarity_positive,
                  input phase, input period_start, output ready);
endinterface

>>> hdl/biphasic_pulse_generator_top.sv
// Biphasic stimulation pulse generator. Each transfer on in_ch is one microsecond
// tick (advance=1) or a status query (advance=0); each produces one transfer on
// out_ch with the drive duty, polarity, phase and period-start flag for the current
// position. Ticks are taken one per cycle and go through a single result register,
// so the block sustains one transfer per clock while out_ch keeps up and the divider
// is idle. After reset and after every register write the period is recomputed as
// 1000000 / frequency by a restoring divider that retires one quotient bit per cycle:
// in_ch.ready stays low while it runs after a write (load, 20 divider steps, final
// compare against the pulse train) and after reset, where the load falls in the last
// reset cycle. in_ch.ready is also low during the access cycle of an APB write.
// Depends on bpg_pkg and bpg_if.
module biphasic_pulse_generator_top
  import bpg_pkg::*;
#(
  parameter int unsigned FREQ_MIN_HZ  = FREQ_MIN_HZ_DEF,
  parameter int unsigned FREQ_MAX_HZ  = FREQ_MAX_HZ_DEF,
  parameter int unsigned WIDTH_MIN_US = WIDTH_MIN_US_DEF,
  parameter int unsigned WIDTH_MAX_US = WIDTH_MAX_US_DEF,
  parameter int unsigned AMP_MIN_Q10  = AMP_MIN_Q10_DEF,
  parameter int unsigned AMP_MAX_Q10  = AMP_MAX_Q10_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  bpg_in_if.sink             in_ch,
  bpg_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [FREQ_W-1:0]  FMIN = FREQ_MIN_HZ[FREQ_W-1:0];
  localparam logic [FREQ_W-1:0]  FMAX = FREQ_MAX_HZ[FREQ_W-1:0];
  localparam logic [WIDTH_W-1:0] WMIN = WIDTH_MIN_US[WIDTH_W-1:0];
  localparam logic [WIDTH_W-1:0] WMAX = WIDTH_MAX_US[WIDTH_W-1:0];
  localparam logic [AMP_W-1:0]   AMIN = AMP_MIN_Q10[AMP_W-1:0];
  localparam logic [AMP_W-1:0]   AMAX = AMP_MAX_Q10[AMP_W-1:0];
  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DIV_STEPS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [FREQ_W-1:0]    freq_r;
  logic [WIDTH_W-1:0]   width_in_r;
  logic [AMP_W-1:0]     amp_r;
  logic                 biph_r;
  logic                 en_r;
  logic [GAP_W-1:0]     gap_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign wr_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r     <= FREQ_RST;
      width_in_r <= WIDTH_RST;
      amp_r      <= AMP_RST;
      biph_r     <= 1'b1;
      en_r       <= 1'b1;
      gap_r      <= GAP_RST;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_FREQ:  freq_r     <= pwdata[FREQ_W-1:0];
        REG_WIDTH: width_in_r <= pwdata[WIDTH_W-1:0];
        REG_AMP:   amp_r      <= pwdata[AMP_W-1:0];
        REG_BIPH:  biph_r     <= pwdata[0];
        REG_EN:    en_r       <= pwdata[0];
        REG_GAP:   gap_r      <= pwdata[GAP_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_FREQ:  prdata = 32'(freq_r);
      REG_WIDTH: prdata = 32'(width_in_r);
      REG_AMP:   prdata = 32'(amp_r);
      REG_BIPH:  prdata = 32'(biph_r);
      REG_EN:    prdata = 32'(en_r);
      REG_GAP:   prdata = 32'(gap_r);
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Clamp the settings: raise to the minimum first, then lower to the maximum
  // ---------------------------------------------------------------------------
  logic [FREQ_W-1:0]  freq_lo, freq_c;
  logic [WIDTH_W-1:0] width_lo, width_c;
  logic [AMP_W-1:0]   amp_lo, amp_c;
  logic [17:0]        train_len;
  logic [16:0]        gap_end;
  logic [17:0]        neg_end;

  always_comb begin
    freq_lo  = (freq_r < FMIN) ? FMIN : freq_r;
    freq_c   = (freq_lo > FMAX) ? FMAX : freq_lo;
    if (freq_c == '0) begin
      freq_c = FREQ_W'(1);  // zero frequency runs as 1 Hz
    end
    width_lo = (width_in_r < WMIN) ? WMIN : width_in_r;
    width_c  = (width_lo > WMAX) ? WMAX : width_lo;
    amp_lo   = (amp_r < AMIN) ? AMIN : amp_r;
    amp_c    = (amp_lo > AMAX) ? AMAX : amp_lo;
    gap_end  = 17'(width_c) + 17'(gap_r);
    neg_end  = 18'(gap_end) + 18'(width_c);
    train_len = biph_r ? neg_end : 18'(width_c);
  end

  // ---------------------------------------------------------------------------
  // Period derivation: restoring divider, one quotient bit per cycle
  // ---------------------------------------------------------------------------
  logic             start_r;   // load the divider next cycle
  logic [CNT_W-1:0] cnt_r;     // divider steps left
  logic             fin_r;     // last cycle: compare quotient with the train
  logic [POS_W-1:0] quo_r;     // dividend bits shift out, quotient bits shift in
  logic [FREQ_W-1:0] rem_r;
  logic [FREQ_W-1:0] dvs_r;
  logic [FREQ_W:0]  trial;
  logic             trial_ge;
  logic [FREQ_W:0]  trial_sub;
  logic             busy;

  assign trial     = {rem_r, quo_r[POS_W-1]};
  assign trial_ge  = trial >= {1'b0, dvs_r};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign busy      = start_r | (cnt_r != '0) | fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
    end else begin
      start_r <= wr_en;
      fin_r   <= !wr_en && !start_r && (cnt_r == CNT_W'(1));
      if (start_r) begin
        cnt_r <= CNT_LOAD;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_r) begin
      quo_r <= US_PER_S;
      rem_r <= '0;
      dvs_r <= freq_c;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[POS_W-2:0], trial_ge};
      rem_r <= trial_ge ? trial_sub[FREQ_W-1:0] : trial[FREQ_W-1:0];
    end
  end

  // Derived per-period values, latched on the final derivation cycle
  logic [POS_W-1:0]   period_r;
  logic [WIDTH_W-1:0] pos_end_r;
  logic [16:0]        gap_end_r;
  logic [17:0]        neg_end_r;
  logic [DUTY_W-1:0]  duty_r;
  logic [POS_W-1:0]   period_nxt;
  logic [20:0]        amp_prod;

  assign amp_prod = 21'(amp_c) * 21'd1023;

  always_comb begin
    period_nxt = (quo_r < POS_W'(train_len)) ? POS_W'(train_len) : quo_r;
    if (period_nxt == '0) begin
      period_nxt = POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fin_r) begin
      period_r  <= period_nxt;
      pos_end_r <= width_c;
      gap_end_r <= gap_end;
      neg_end_r <= neg_end;
      duty_r    <= amp_prod[AMP_W+DUTY_W-2:AMP_W-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Tick step: position counter, phase decode, result register
  // ---------------------------------------------------------------------------
  logic             in_fire;
  logic             out_valid_r;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_cur, pos_inc;
  phase_t           ph;
  logic [DUTY_W-1:0] duty_nxt;

  assign in_ch.ready = !busy && !wr_en && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid & in_ch.ready;

  always_comb begin
    // A write may have shortened the period: restart from position 0
    pos_cur = (pos_r >= period_r) ? '0 : pos_r;
    pos_inc = pos_cur + POS_W'(1);
    priority if (POS_W'(pos_end_r) > pos_cur) begin
      ph = PH_POS;
    end else if (biph_r && (POS_W'(gap_end_r) > pos_cur)) begin
      ph = PH_GAP;
    end else if (biph_r && (POS_W'(neg_end_r) > pos_cur)) begin
      ph = PH_NEG;
    end else begin
      ph = PH_REST;
    end
    duty_nxt = ((ph == PH_POS) || (ph == PH_NEG)) ? duty_r : '0;
    priority if (!en_r) begin
      pos_nxt = '0;
    end else if (in_ch.advance) begin
      pos_nxt = (pos_inc >= period_r) ? '0 : pos_inc;
    end else begin
      pos_nxt = pos_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        pos_r <= pos_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  logic [DUTY_W-1:0] duty_out_r;
  logic              pol_out_r;
  phase_t            phase_out_r;
  logic              pstart_out_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (en_r) begin
        duty_out_r   <= duty_nxt;
        pol_out_r    <= (ph != PH_NEG);
        phase_out_r  <= ph;
        pstart_out_r <= (pos_cur == '0);
      end else begin
        // Disabled: hold the output stage idle
        duty_out_r   <= '0;
        pol_out_r    <= 1'b1;
        phase_out_r  <= PH_REST;
        pstart_out_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.drive_duty        = duty_out_r;
  assign out_ch.polarity_positive = pol_out_r;
  assign out_ch.phase             = phase_out_r;
  assign out_ch.period_start      = pstart_out_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_wr_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> start_r && !in_ch.ready)
    else $error("register write did not restart the period derivation");

  a_pos_in_period: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pos_r < period_r)
    else $error("position left the period after a tick");

  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted tick produced no result");

  a_neg_polarity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((phase_out_r == PH_NEG) == !pol_out_r))
    else $error("polarity disagrees with phase");

  a_duty_in_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (duty_out_r != '0)) |-> (phase_out_r == PH_POS || phase_out_r == PH_NEG))
    else $error("drive active outside a pulse phase");

endmodule

>>> test/biphasic_pulse_generator_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for biphasic_pulse_generator_top: drives microsecond ticks,
// programs the APB registers and scores every drive result against a local model of
// the pulse train. Depends on bpg_pkg, bpg_if and the top level.
module biphasic_pulse_generator_top_test;
  import bpg_pkg::*;

  // Run shape
  localparam int RAND_PHASES     = 10;
  localparam int TICKS_PER_PHASE = 103;
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off, fills the block
  localparam int QUIET_LIMIT     = 3000;  // cycles without any transfer before giving up
  localparam int END_SETTLE      = 25;

  localparam int unsigned POS_MASK  = (1 << POS_W) - 1;
  localparam int unsigned DUTY_FULL = (1 << DUTY_W) - 1;

  // Register slots past the end of the map; writes there must change nothing
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              pol;
    phase_t            phase;
    logic              start;
  } pulse_out_t;

  localparam pulse_out_t NO_PIN = '0;

  typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [REG_IDX_W-1:0] idx;
    logic [31:0]          data;
    logic                 adv;
    logic                 pinned;
    pulse_out_t           want;
  } plan_row_t;

  // Directed plan. Pinned rows carry a result that follows directly from reset values,
  // clamp extremes or the disabled state; the others are scored by the model.
  localparam int PLAN_LEN = 37;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // after reset: duty 511, first tick of the period
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b0, 1'b1, '{10'd511,  1'b1, PH_POS,  1'b1}},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b1, 1'b1, '{10'd511,  1'b1, PH_POS,  1'b1}},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b1, 1'b1, '{10'd511,  1'b1, PH_POS,  1'b0}},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b0, 1'b1, '{10'd511,  1'b1, PH_POS,  1'b0}},
    // amplitude over the top clamps to full scale
    '{ROW_WRITE, REG_AMP,       32'h0000_07FF,  1'b0, 1'b0, NO_PIN},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b1, 1'b1, '{10'd1023, 1'b1, PH_POS,  1'b0}},
    '{ROW_WRITE, REG_AMP,       32'd0,          1'b0, 1'b0, NO_PIN},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b1, 1'b1, '{10'd0,    1'b1, PH_POS,  1'b0}},
    '{ROW_WRITE, REG_AMP,       32'd1024,       1'b0, 1'b0, NO_PIN},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b0, 1'b0, NO_PIN},
    // frequency extremes: zero clamps up, all ones clamps down
    '{ROW_WRITE, REG_FREQ,      32'd0,          1'b0, 1'b0, NO_PIN},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b1, 1'b0, NO_PIN},
    '{ROW_WRITE, REG_FREQ,      32'hFFFF_FFFF,  1'b0, 1'b0, NO_PIN},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b1, 1'b0, NO_PIN},
    // pulse width extremes
    '{ROW_WRITE, REG_WIDTH,     32'd0,          1'b0, 1'b0, NO_PIN},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b1, 1'b0, NO_PIN},
    '{ROW_WRITE, REG_WIDTH,     32'h0000_FFFF,  1'b0, 1'b0, NO_PIN},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b1, 1'b0, NO_PIN},
    // gap extremes and monophasic mode
    '{ROW_WRITE, REG_GAP,       32'h0000_03FF,  1'b0, 1'b0, NO_PIN},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b1, 1'b0, NO_PIN},
    '{ROW_WRITE, REG_GAP,       32'd0,          1'b0, 1'b0, NO_PIN},
    '{ROW_WRITE, REG_BIPH,      32'd0,          1'b0, 1'b0, NO_PIN},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b1, 1'b0, NO_PIN},
    '{ROW_WRITE, REG_BIPH,      32'd1,          1'b0, 1'b0, NO_PIN},
    // disabled: idle output, position cleared
    '{ROW_WRITE, REG_EN,        32'd0,          1'b0, 1'b0, NO_PIN},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b1, 1'b1, '{10'd0,    1'b1, PH_REST, 1'b0}},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b0, 1'b1, '{10'd0,    1'b1, PH_REST, 1'b0}},
    '{ROW_WRITE, REG_EN,        32'd1,          1'b0, 1'b0, NO_PIN},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b0, 1'b1, '{10'd1023, 1'b1, PH_POS,  1'b1}},
    // writes past the register map are dropped
    '{ROW_WRITE, REG_UNUSED_LO, 32'hFFFF_FFFF,  1'b0, 1'b0, NO_PIN},
    '{ROW_WRITE, REG_UNUSED_HI, 32'hFFFF_FFFF,  1'b0, 1'b0, NO_PIN},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b1, 1'b1, '{10'd1023, 1'b1, PH_POS,  1'b1}},
    '{ROW_TICK,  REG_FREQ,      32'd0,          1'b1, 1'b1, '{10'd1023, 1'b1, PH_POS,  1'b0}},
    // back to the reset settings
    '{ROW_WRITE, REG_FREQ,      32'd100,        1'b0, 1'b0, NO_PIN},
    '{ROW_WRITE, REG_WIDTH,     32'd100,        1'b0, 1'b0, NO_PIN},
    '{ROW_WRITE, REG_AMP,       32'd512,        1'b0, 1'b0, NO_PIN},
    '{ROW_WRITE, REG_GAP,       32'd50,         1'b0, 1'b0, NO_PIN}
  };

  logic clk;
  logic rst_n;

  bpg_in_if  in_ch ();
  bpg_out_if out_ch ();

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  biphasic_pulse_generator_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Register copies and pulse train state of the model
  logic [FREQ_W-1:0]  set_freq;
  logic [WIDTH_W-1:0] set_width;
  logic [AMP_W-1:0]   set_amp;
  logic               set_biph;
  logic               set_en;
  logic [GAP_W-1:0]   set_gap;
  int unsigned        train_pos;
  int unsigned        train_period;
  int unsigned        train_duty;

  pulse_out_t pending_outputs [$];
  int unsigned ticks_offered;
  int unsigned results_taken;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  // Sideband that travels with each offered tick: a pinned result for directed rows
  logic       pin_q;
  pulse_out_t pin_want_q;

  // Idle percentages of sender and receiver, and hold-off requests to the receiver
  int unsigned tx_pct;
  int unsigned rx_pct;
  int unsigned hold_asked;
  int unsigned hold_served;
  int unsigned hold_left;

  // ---------------------------------------------------------------- model

  function automatic int unsigned clamp_range(int unsigned x, int unsigned lo,
                                              int unsigned hi);
    // raise to the floor first, then lower to the ceiling
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic int unsigned width_eff();
    return clamp_range(32'(set_width), WIDTH_MIN_US_DEF, WIDTH_MAX_US_DEF);
  endfunction

  // Recompute period and duty level from the register copies
  function automatic void retime_train();
    int unsigned f;
    int unsigned per;
    int unsigned train;
    int unsigned amp;
    f = clamp_range(32'(set_freq), FREQ_MIN_HZ_DEF, FREQ_MAX_HZ_DEF);
    if (f == 0) f = 1;
    per   = int'(US_PER_S) / f;
    train = set_biph ? 2 * width_eff() + 32'(set_gap) : width_eff();
    if (per < train) per = train;
    if (per == 0) per = 1;
    train_period = per & POS_MASK;
    amp        = clamp_range(32'(set_amp), AMP_MIN_Q10_DEF, AMP_MAX_Q10_DEF);
    train_duty = ((amp * DUTY_FULL) >> 10) & DUTY_FULL;
  endfunction

  function automatic void store_setting(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      REG_FREQ:  set_freq  = data[FREQ_W-1:0];
      REG_WIDTH: set_width = data[WIDTH_W-1:0];
      REG_AMP:   set_amp   = data[AMP_W-1:0];
      REG_BIPH:  set_biph  = data[0];
      REG_EN:    set_en    = data[0];
      REG_GAP:   set_gap   = data[GAP_W-1:0];
      default:   return;
    endcase
    retime_train();
  endfunction

  function automatic logic [31:0] setting_value(logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_FREQ:  return 32'(set_freq);
      REG_WIDTH: return 32'(set_width);
      REG_AMP:   return 32'(set_amp);
      REG_BIPH:  return 32'(set_biph);
      REG_EN:    return 32'(set_en);
      REG_GAP:   return 32'(set_gap);
      default:   return 32'd0;
    endcase
  endfunction

  // Output for the current position, then move on by one microsecond if asked
  function automatic pulse_out_t step_pulse_train(logic adv);
    pulse_out_t r;
    int unsigned pw;
    r.duty  = '0;
    r.pol   = 1'b1;
    r.phase = PH_REST;
    r.start = 1'b0;
    if (!set_en) begin
      train_pos = 0;
      return r;
    end
    // a write may have shortened the period under the current position
    if (train_pos >= train_period) train_pos = 0;
    pw = width_eff();
    if (train_pos < pw) r.phase = PH_POS;
    else if (set_biph && train_pos < pw + 32'(set_gap)) r.phase = PH_GAP;
    else if (set_biph && train_pos < 2 * pw + 32'(set_gap)) r.phase = PH_NEG;
    else r.phase = PH_REST;
    if (r.phase == PH_POS || r.phase == PH_NEG) r.duty = DUTY_W'(train_duty);
    r.pol   = (r.phase != PH_NEG);
    r.start = (train_pos == 0);
    if (adv) begin
      train_pos = (train_pos + 1) & POS_MASK;
      if (train_pos >= train_period) train_pos = 0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- clock and reset

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------- scoring

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Score results first, so a result never pairs with a tick taken at the same edge.
  always @(posedge clk) begin
    pulse_out_t want;
    if (rst_n) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        results_taken++;
        if (pending_outputs.size() == 0) begin
          flag_mismatch("result transfer with nothing pending", 32'(out_ch.drive_duty), 0);
        end else begin
          want = pending_outputs.pop_front();
          if (out_ch.drive_duty !== want.duty)
            flag_mismatch("drive_duty", 32'(out_ch.drive_duty), 32'(want.duty));
          if (out_ch.polarity_positive !== want.pol)
            flag_mismatch("polarity_positive", 32'(out_ch.polarity_positive),
                          32'(want.pol));
          if (out_ch.phase !== want.phase)
            flag_mismatch("phase", 32'(out_ch.phase), 32'(want.phase));
          if (out_ch.period_start !== want.start)
            flag_mismatch("period_start", 32'(out_ch.period_start), 32'(want.start));
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        // advance the model even for pinned rows, so its state stays in step
        want = step_pulse_train(in_ch.advance);
        if (pin_q) want = pin_want_q;
        pending_outputs.push_back(want);
      end
    end
    // Watchdog: count edges with no transfer on either channel
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- receiver

  // Drop ready at random per rx_pct; on request, hold it low for a long stretch
  // counted here, while the sender keeps offering ticks.
  initial begin
    out_ch.ready = 1'b0;
    hold_served  = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_pct);
      end
    end
  end

  // ---------------------------------------------------------------- sender and APB

  // Offer one tick and hold it until the transfer; called and returns at a clock edge.
  task automatic offer_tick(input logic adv, input logic pin, input pulse_out_t want);
    while ($urandom_range(99) < tx_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.advance <= adv;
    pin_q         <= pin;
    pin_want_q    <= want;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    ticks_offered++;
  endtask

  // Stop offering and wait until every result is back; no result is then pending.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (results_taken != ticks_offered) @(posedge clk);
  endtask

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    store_setting(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_check_read(input logic [REG_IDX_W-1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== setting_value(idx)) flag_mismatch("register read", prdata, setting_value(idx));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Program a fresh random setting, with the extremes drawn often, and read it back.
  task automatic roll_settings();
    logic [31:0] f;
    logic [31:0] w;
    logic [31:0] a;
    logic [31:0] g;
    logic [31:0] e;
    logic [31:0] b;
    case ($urandom_range(5))
      0:       f = 32'd0;
      1:       f = 32'd1;
      2:       f = 32'(FREQ_MAX_HZ_DEF);
      3:       f = 32'h0000_03FF;
      default: f = $urandom;
    endcase
    case ($urandom_range(6))
      0:       w = 32'd0;
      1:       w = 32'(WIDTH_MAX_US_DEF);
      2:       w = 32'h0000_FFFF;
      3:       w = $urandom;
      default: w = $urandom_range(120);  // short pulses, so the whole train shows up
    endcase
    case ($urandom_range(4))
      0:       a = 32'd0;
      1:       a = 32'(AMP_MAX_Q10_DEF);
      2:       a = 32'h0000_07FF;
      default: a = $urandom;
    endcase
    case ($urandom_range(4))
      0:       g = 32'd0;
      1:       g = 32'h0000_03FF;
      2:       g = $urandom;
      default: g = $urandom_range(40);
    endcase
    // keep the train running most of the time; upper bits are don't-care
    e = {31'($urandom_range(32'h7FFF_FFFF)), 1'b0} | 32'($urandom_range(5) != 0);
    b = $urandom;
    apb_write(REG_FREQ,  f);
    apb_write(REG_WIDTH, w);
    apb_write(REG_AMP,   a);
    apb_write(REG_BIPH,  b);
    apb_write(REG_EN,    e);
    apb_write(REG_GAP,   g);
    apb_write($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI, $urandom);
    for (int i = 0; i <= int'(REG_GAP); i++) apb_check_read(REG_IDX_W'(i));
  endtask

  // ---------------------------------------------------------------- stimulus

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.advance = 1'b0;
    pin_q         = 1'b0;
    pin_want_q    = NO_PIN;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    tx_pct        = 0;
    rx_pct        = 0;
    hold_asked    = 0;
    ticks_offered = 0;
    results_taken = 0;
    mismatches    = 0;
    quiet_cycles  = 0;

    // reset contents of the model
    set_freq  = FREQ_RST;
    set_width = WIDTH_RST;
    set_amp   = AMP_RST;
    set_biph  = 1'b1;
    set_en    = 1'b1;
    set_gap   = GAP_RST;
    train_pos = 0;
    retime_train();

    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);

    // Directed plan, with light idling on both sides
    tx_pct = 16;
    rx_pct = 16;
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        drain();
        apb_write(PLAN[i].idx, PLAN[i].data);
      end else begin
        offer_tick(PLAN[i].adv, PLAN[i].pinned, PLAN[i].want);
      end
    end

    // Random phases: new settings each time, cycling through the idling patterns
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      roll_settings();
      case (ph % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 68; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 68; end
        default: begin tx_pct = 16; rx_pct = 16; end
      endcase
      // back-pressure once: receiver holds off while ticks keep coming
      if (ph == 0) hold_asked++;
      repeat (TICKS_PER_PHASE) offer_tick($urandom_range(9) < 8, 1'b0, NO_PIN);
    end

    drain();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
